@@ rtl/mnms_pkg.sv @@
// shared constants, register indexes and control structs for the match selector
package mnms_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_KEYPOINTS = 64;
    localparam int DEF_SCORE_BITS    = 16;

    // fixed field widths
    localparam int CNT_BITS     = 7;
    localparam int THR_BITS     = 16;
    localparam int OUT_IDX_BITS = 6;
    localparam int CFG_IDX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COL_COUNT      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOG_THRESHOLD  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SIDE_COUNT = 2'd3;

    // configuration reset values
    localparam logic [CNT_BITS-1:0]        ROW_COUNT_RST      = 7'd64;
    localparam logic [CNT_BITS-1:0]        COL_COUNT_RST      = 7'd64;
    localparam logic signed [THR_BITS-1:0] LOG_THRESHOLD_RST  = -16'sd412;
    localparam logic [CNT_BITS-1:0]        MIN_SIDE_COUNT_RST = 7'd10;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit_clear;
        logic rd_row;
        logic rd_col;
        logic emit_next;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit_last;
    } dp_status_t;

endpackage

@@ rtl/mnms_ctrl.sv @@
// controller state machine: load, drain and per-row emission sequencing
module mnms_ctrl
    import mnms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       final_flag,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       result_valid
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DRAIN  = 3'd1;
    localparam logic [2:0] S_RD_ROW = 3'd2;
    localparam logic [2:0] S_RD_COL = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        result_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start && final_flag)
                begin
                    cmd.emit_clear = 1'b1;
                    state_next     = S_DRAIN;
                end
            end
            // last item still writing its stores
            S_DRAIN:
            begin
                state_next = S_RD_ROW;
            end
            S_RD_ROW:
            begin
                cmd.rd_row = 1'b1;
                state_next = S_RD_COL;
            end
            S_RD_COL:
            begin
                cmd.rd_col = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                result_valid = 1'b1;
                if (status.emit_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.emit_next = 1'b1;
                    state_next    = S_RD_ROW;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/mnms_datapath.sv @@
// datapath: config registers, position counters, argmax stores and result logic
module mnms_datapath
    import mnms_pkg::*;
#(
    parameter int MAX_KEYPOINTS = DEF_MAX_KEYPOINTS,
    parameter int SCORE_BITS    = DEF_SCORE_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ctrl_cmd_t                      cmd,
    output dp_status_t                     status,
    input  logic signed [SCORE_BITS-1:0]   score,
    input  logic                           final_flag,
    input  logic                           cfg_we,
    input  logic [CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [THR_BITS-1:0]            cfg_data,
    output logic [OUT_IDX_BITS-1:0]        row_index,
    output logic [OUT_IDX_BITS-1:0]        col_index,
    output logic                           matched,
    output logic signed [SCORE_BITS-1:0]   match_score,
    output logic                           last_result
);

    localparam int IDX_BITS = $clog2(MAX_KEYPOINTS);
    localparam int ENT_BITS = SCORE_BITS + IDX_BITS;
    localparam int CMP_BITS = (SCORE_BITS > THR_BITS) ? SCORE_BITS : THR_BITS;
    localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_KEYPOINTS);
    localparam logic [CNT_BITS-1:0] ONE_CNT = CNT_BITS'(1);

    // configuration
    logic [CNT_BITS-1:0]        row_count_reg;
    logic [CNT_BITS-1:0]        col_count_reg;
    logic signed [THR_BITS-1:0] log_threshold_reg;
    logic [CNT_BITS-1:0]        min_side_count_reg;

    logic [CNT_BITS-1:0] rows;
    logic [CNT_BITS-1:0] cols;

    // load positions
    logic [CNT_BITS-1:0] row_pos_reg;
    logic [CNT_BITS-1:0] row_pos_next;
    logic [CNT_BITS-1:0] col_pos_reg;
    logic [CNT_BITS-1:0] col_pos_next;
    logic                in_range;

    // update stage
    logic                         st1_valid_reg;
    logic signed [SCORE_BITS-1:0] st1_score_reg;
    logic [IDX_BITS-1:0]          st1_row_reg;
    logic [IDX_BITS-1:0]          st1_col_reg;
    logic                         st1_first_col_reg;
    logic                         st1_first_row_reg;

    // running row best
    logic signed [SCORE_BITS-1:0] row_run_val_reg;
    logic [IDX_BITS-1:0]          row_run_col_reg;
    logic                         row_take;
    logic signed [SCORE_BITS-1:0] row_new_val;
    logic [IDX_BITS-1:0]          row_new_col;

    // column store read-modify-write with forwarding
    logic [ENT_BITS-1:0]          col_mem [MAX_KEYPOINTS];
    logic [ENT_BITS-1:0]          col_rd_reg;
    logic [IDX_BITS-1:0]          col_addr;
    logic                         fwd_valid_reg;
    logic [ENT_BITS-1:0]          fwd_data_reg;
    logic [ENT_BITS-1:0]          col_old;
    logic signed [SCORE_BITS-1:0] col_old_val;
    logic                         col_take;
    logic [ENT_BITS-1:0]          col_new;

    // row store
    logic [ENT_BITS-1:0]          row_mem [MAX_KEYPOINTS];
    logic [ENT_BITS-1:0]          row_rd_reg;
    logic signed [SCORE_BITS-1:0] row_rd_val;
    logic [IDX_BITS-1:0]          row_rd_col;

    // emission
    logic [CNT_BITS-1:0]          emit_idx_reg;
    logic [IDX_BITS-1:0]          col_rd_row;
    logic                         sizes_ok;
    logic signed [CMP_BITS-1:0]   thr_ext;
    logic signed [CMP_BITS-1:0]   val_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg      <= ROW_COUNT_RST;
            col_count_reg      <= COL_COUNT_RST;
            log_threshold_reg  <= LOG_THRESHOLD_RST;
            min_side_count_reg <= MIN_SIDE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_COUNT:      row_count_reg      <= cfg_data[CNT_BITS-1:0];
                REG_COL_COUNT:      col_count_reg      <= cfg_data[CNT_BITS-1:0];
                REG_LOG_THRESHOLD:  log_threshold_reg  <= cfg_data;
                REG_MIN_SIDE_COUNT: min_side_count_reg <= cfg_data[CNT_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // clamp sizes to 1..max
    always_comb
    begin
        if (row_count_reg == '0)
            rows = ONE_CNT;
        else if (row_count_reg > MAX_CNT)
            rows = MAX_CNT;
        else
            rows = row_count_reg;
        if (col_count_reg == '0)
            cols = ONE_CNT;
        else if (col_count_reg > MAX_CNT)
            cols = MAX_CNT;
        else
            cols = col_count_reg;
    end

    assign in_range = (row_pos_reg < rows) && (col_pos_reg < cols);

    // row position passes the last row and holds there until the frame ends
    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (cmd.load)
        begin
            if (in_range)
            begin
                if ((col_pos_reg + ONE_CNT) >= cols)
                begin
                    col_pos_next = '0;
                    row_pos_next = row_pos_reg + ONE_CNT;
                end
                else
                begin
                    col_pos_next = col_pos_reg + ONE_CNT;
                end
            end
            if (final_flag)
            begin
                row_pos_next = '0;
                col_pos_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            st1_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            row_pos_reg   <= row_pos_next;
            col_pos_reg   <= col_pos_next;
            st1_valid_reg <= cmd.load && in_range;
            fwd_valid_reg <= st1_valid_reg && (st1_col_reg == col_pos_reg[IDX_BITS-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        st1_score_reg     <= score;
        st1_row_reg       <= row_pos_reg[IDX_BITS-1:0];
        st1_col_reg       <= col_pos_reg[IDX_BITS-1:0];
        st1_first_col_reg <= (col_pos_reg == '0);
        st1_first_row_reg <= (row_pos_reg == '0);
        fwd_data_reg      <= col_new;
    end

    // row argmax: first element of the row always takes, later ones on strict greater
    always_comb
    begin
        row_take    = st1_first_col_reg || (st1_score_reg > row_run_val_reg);
        row_new_val = row_take ? st1_score_reg : row_run_val_reg;
        row_new_col = row_take ? st1_col_reg : row_run_col_reg;
    end

    // column argmax: store read registered alongside the update stage, newest write forwarded
    always_comb
    begin
        col_old     = fwd_valid_reg ? fwd_data_reg : col_rd_reg;
        col_old_val = col_old[ENT_BITS-1:IDX_BITS];
        col_take    = st1_first_row_reg || (st1_score_reg > col_old_val);
        col_new     = col_take ? {st1_score_reg, st1_row_reg} : col_old;
    end

    assign row_rd_val = row_rd_reg[ENT_BITS-1:IDX_BITS];
    assign row_rd_col = row_rd_reg[IDX_BITS-1:0];
    assign col_rd_row = col_rd_reg[IDX_BITS-1:0];
    assign col_addr   = cmd.rd_col ? row_rd_col : col_pos_reg[IDX_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (st1_valid_reg)
        begin
            row_run_val_reg      <= row_new_val;
            row_run_col_reg      <= row_new_col;
            row_mem[st1_row_reg] <= {row_new_val, row_new_col};
            col_mem[st1_col_reg] <= col_new;
        end
        col_rd_reg <= col_mem[col_addr];
        if (cmd.rd_row)
        begin
            row_rd_reg <= row_mem[emit_idx_reg[IDX_BITS-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_idx_reg <= '0;
        end
        else if (cmd.emit_clear)
        begin
            emit_idx_reg <= '0;
        end
        else if (cmd.emit_next)
        begin
            emit_idx_reg <= emit_idx_reg + ONE_CNT;
        end
    end

    assign status.emit_last = ((emit_idx_reg + ONE_CNT) == rows);

    always_comb
    begin
        sizes_ok = (rows >= min_side_count_reg) && (cols >= min_side_count_reg);
        thr_ext  = CMP_BITS'(log_threshold_reg);
        val_ext  = CMP_BITS'(row_rd_val);
        matched  = sizes_ok && (col_rd_row == emit_idx_reg[IDX_BITS-1:0]) &&
                   (val_ext > thr_ext);
    end

    assign row_index   = OUT_IDX_BITS'(emit_idx_reg[IDX_BITS-1:0]);
    assign col_index   = OUT_IDX_BITS'(row_rd_col);
    assign match_score = row_rd_val;
    assign last_result = status.emit_last;

endmodule

@@ rtl/mutual_nearest_match_selector_core.sv @@
// top level of the mutual nearest-neighbour match selector
//
// usage
// - score matrix channel: one score per transfer in row-major order, taken at a
//   rising edge with start high and busy low; final_flag marks the last element
// - loading runs at one score per cycle; busy stays low until the final score
// - per-row argmax lives in the row store, per-column argmax in the column store;
//   each score is read-modified-written in the column store in the cycle after it
//   is taken, with the newest write forwarded for back-to-back same-column hits
// - after the final score: a drain state, then per row a row store read, a
//   column store read at the chosen column and the result; busy stays high
//   until the last result
// - results: result_valid is high for exactly one cycle per row, in row order,
//   last_result flags the final row; the receiver cannot hold results off
// - configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, taken only
//   while busy and start are both low; write it between frames
// - reset: control state and config registers return to defaults; the stores
//   are not reset and must be filled by a frame before their rows are meaningful
module mutual_nearest_match_selector_core
    import mnms_pkg::*;
#(
    parameter int MAX_KEYPOINTS = DEF_MAX_KEYPOINTS,
    parameter int SCORE_BITS    = DEF_SCORE_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // score matrix channel
    input  logic                         start,
    output logic                         busy,
    input  logic signed [SCORE_BITS-1:0] score,
    input  logic                         final_flag,
    // configuration channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [THR_BITS-1:0]          cfg_data,
    // result channel
    output logic                         result_valid,
    output logic [OUT_IDX_BITS-1:0]      row_index,
    output logic [OUT_IDX_BITS-1:0]      col_index,
    output logic                         matched,
    output logic signed [SCORE_BITS-1:0] match_score,
    output logic                         last_result
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // register writes never beside a score transfer; keeping them between frames is up to the user, not enforced here
    assign cfg_ready = !busy && !start;

    mnms_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .final_flag   (final_flag),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    mnms_datapath #(
        .MAX_KEYPOINTS (MAX_KEYPOINTS),
        .SCORE_BITS    (SCORE_BITS)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .score       (score),
        .final_flag  (final_flag),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .row_index   (row_index),
        .col_index   (col_index),
        .matched     (matched),
        .match_score (match_score),
        .last_result (last_result)
    );

endmodule

@@ rtl/mnms_checker.sv @@
// port-level checker for the match selector, bound to the top level
module mnms_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic final_flag,
    input logic result_valid,
    input logic last_result
);

    // results only come out during emission
    a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe while not busy");

    // the final transfer starts emission
    a_final_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && final_flag) |=> busy)
        else $error("busy did not rise after final transfer");

    // rows are spaced apart by the store reads
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for two cycles");

    // the last row ends the run
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_result) |=> !busy)
        else $error("still busy after last result");

    // nothing comes out of an idle block
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !result_valid)
        else $error("result strobe straight out of idle");

endmodule

bind mutual_nearest_match_selector_core mnms_checker u_mnms_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .final_flag   (final_flag),
    .result_valid (result_valid),
    .last_result  (last_result)
);
